// ===== hdl/ccvc_pkg.sv =====
// Package for the channel crossfade volume controller.
// Holds command codes, fade phase codes and level limits; no dependencies.
package ccvc_pkg;
	typedef enum logic [2:0] {
		ACT_PLAY  = 3'd0,
		ACT_STOP  = 3'd1,
		ACT_SETV  = 3'd2,
		ACT_TICK  = 3'd3,
		ACT_ENDED = 3'd4
	} action_t;

	localparam logic [1:0] PHASE_STEADY = 2'd0;
	localparam logic [1:0] PHASE_IN     = 2'd1;
	localparam logic [1:0] PHASE_OUT    = 2'd2;
	localparam logic [7:0] MAX_LEVEL    = 8'd128;
	localparam int         MAX_REPORTED = 8;
endpackage

// ===== hdl/ccvc_div.sv =====
// Bit-serial restoring divider: 24-bit dividend by 16-bit divisor, 8-bit quotient.
// One quotient bit per cycle. No dependencies.
module ccvc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [7:0]  quotient
);
	logic [23:0] num_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], num_q[23]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			// shift in one dividend bit, subtract where it fits
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				num_q <= {num_q[22:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[22:0], 1'b0};
			end
		end
	end

	// quotient bits accumulate in the low end of num_q; results fit in 8 bits
	assign quotient = num_q[7:0];
endmodule

// ===== hdl/channel_crossfade_volume_controller_top.sv =====
// Channel crossfade volume controller, top level.
// Depends on ccvc_pkg and ccvc_div.
//
//  channel | direction | fields                                              | handshake
//  in      | input     | action channel level fade_out_ms fade_in_ms now_ms  | in_valid/in_stall
//  out     | output    | out_channel out_level is_active fade_phase last     | out_valid/out_stall
//
// Flow: a command passes from S_IDLE through S_CMD to S_OUT and back to S_IDLE
// before the next input transfer. A tick walks the channels one after another; a
// channel in an unfinished fade loads the serial divider and waits in S_DIV for
// its 24 quotient bits, any other channel is handled in S_TCH alone. Each result
// is then reported through S_REP and S_OUT; the divider makes one bit per cycle.
// Reset clears every channel's state at once; all levels and flags read zero.
// Output stall holds the result register; no new item is taken until every
// result of the current one has been transferred.
module channel_crossfade_volume_controller_top
	import ccvc_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [2:0]  channel,
	input  logic [7:0]  level,
	input  logic [15:0] fade_out_ms,
	input  logic [15:0] fade_in_ms,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_channel,
	output logic [7:0]  out_level,
	output logic        is_active,
	output logic [1:0]  fade_phase,
	output logic        last
);
	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REP = (CHANNELS < MAX_REPORTED) ? CHANNELS : MAX_REPORTED;

	typedef enum logic [2:0] {
		S_IDLE, S_CMD, S_TCH, S_DIV, S_REP, S_OUT
	} state_t;

	// per-channel state, each entry read at one channel index
	logic [CHANNELS-1:0] act_q, end_q, pend_q;
	logic [7:0]  cur_q   [CHANNELS];
	logic [7:0]  tgt_q   [CHANNELS];
	logic [15:0] qfin_q  [CHANNELS];
	logic [31:0] fib_q   [CHANNELS];
	logic [15:0] fil_q   [CHANNELS];
	logic [31:0] fob_q   [CHANNELS];
	logic [15:0] fol_q   [CHANNELS];
	logic [7:0]  from_q  [CHANNELS];

	state_t      state_q;
	logic [2:0]  act_in_q, ch_in_q;
	logic [7:0]  lvl_in_q;
	logic [15:0] fout_in_q, fin_in_q;
	logic [31:0] now_in_q;
	logic [CW:0] idx_q;
	logic [CW-1:0] ix;

	logic        div_start, div_done;
	logic [23:0] div_num;
	logic [15:0] div_den;
	logic [7:0]  div_quo;

	ccvc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_quo)
	);

	assign ix       = idx_q[CW-1:0];
	assign in_stall = (state_q != S_IDLE);

	// fade arithmetic for the channel under the tick walk
	logic [31:0] dout, din;
	logic        out_over, in_over;
	assign dout     = now_in_q - fob_q[ix];
	assign din      = now_in_q - fib_q[ix];
	assign out_over = (dout >= {16'b0, fol_q[ix]});
	assign in_over  = (din  >= {16'b0, fil_q[ix]});

	// 8x16 product register feeds the divider; loaded together with its start strobe
	logic [23:0] prod_s1;
	logic [15:0] len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			act_q     <= '0;
			end_q     <= '0;
			pend_q    <= '0;
			out_valid <= 1'b0;
			div_start <= 1'b0;
			idx_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i] <= '0; tgt_q[i] <= '0; qfin_q[i] <= '0; fib_q[i] <= '0;
				fil_q[i] <= '0; fob_q[i] <= '0; fol_q[i] <= '0; from_q[i] <= '0;
			end
		end else begin
			div_start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_in_q  <= action;
						ch_in_q   <= channel;
						lvl_in_q  <= (level > MAX_LEVEL) ? MAX_LEVEL : level;
						fout_in_q <= fade_out_ms;
						fin_in_q  <= fade_in_ms;
						now_in_q  <= now_ms;
						idx_q     <= '0;
						if (action == ACT_TICK) state_q <= S_TCH;
						else if (action > ACT_ENDED) state_q <= S_IDLE;
						else state_q <= S_CMD;
					end
				end
				S_CMD: begin
					out_channel <= ch_in_q;
					last        <= 1'b1;
					state_q     <= S_OUT;
					out_valid   <= 1'b1;
					if (32'(ch_in_q) >= 32'(CHANNELS)) begin
						out_level  <= '0;
						is_active  <= 1'b0;
						fade_phase <= PHASE_STEADY;
					end else begin : cmd
						logic [CW-1:0] c;
						logic a, e, p, fo_act;
						logic [7:0] cu, tg, fr;
						logic [15:0] qf, fl, ol;
						logic [31:0] fb, ob;
						c = CW'(ch_in_q);
						a = act_q[c]; e = end_q[c]; p = pend_q[c];
						cu = cur_q[c]; tg = tgt_q[c]; fr = from_q[c];
						qf = qfin_q[c]; fl = fil_q[c]; ol = fol_q[c];
						fb = fib_q[c]; ob = fob_q[c];
						fo_act = (fout_in_q != 16'd0) && a;
						case (act_in_q)
							ACT_PLAY: begin
								if (fo_act) begin
									p = 1'b1; tg = lvl_in_q; qf = fin_in_q; fr = cu;
									ob = now_in_q; ol = fout_in_q; fb = '0; fl = '0;
								end else begin
									a = 1'b1; e = 1'b0; p = 1'b0; tg = lvl_in_q;
									qf = '0; ob = '0; ol = '0; fr = '0;
									cu = (fin_in_q != 16'd0) ? 8'd0 : lvl_in_q;
									fb = (fin_in_q != 16'd0) ? now_in_q : 32'd0;
									fl = fin_in_q;
								end
							end
							ACT_STOP: begin
								if (fo_act) begin
									p = 1'b0; qf = '0; fr = cu; ob = now_in_q;
									ol = fout_in_q; fb = '0; fl = '0;
								end else begin
									a = 0; e = 0; p = 0; cu = '0; tg = '0; qf = '0;
									fb = '0; fl = '0; ob = '0; ol = '0; fr = '0;
								end
							end
							ACT_SETV: begin
								if (a) begin cu = lvl_in_q; tg = lvl_in_q; end
							end
							default: begin
								if (a) e = 1'b1;
							end
						endcase
						act_q[c] <= a; end_q[c] <= e; pend_q[c] <= p;
						cur_q[c] <= cu; tgt_q[c] <= tg; from_q[c] <= fr;
						qfin_q[c] <= qf; fil_q[c] <= fl; fol_q[c] <= ol;
						fib_q[c] <= fb; fob_q[c] <= ob;
						out_level  <= cu;
						is_active  <= a;
						fade_phase <= (ol != 0) ? PHASE_OUT : ((fl != 0) ? PHASE_IN : PHASE_STEADY);
					end
				end
				S_TCH: begin
					// update one channel; start the divider where a fade is mid-way
					if (idx_q == (CW+1)'(CHANNELS)) begin
						state_q <= S_REP;
						idx_q   <= '0;
					end else if (end_q[ix] || (fol_q[ix] != 0 && out_over && !pend_q[ix])) begin
						act_q[ix] <= 0; end_q[ix] <= 0; pend_q[ix] <= 0;
						cur_q[ix] <= '0; tgt_q[ix] <= '0; qfin_q[ix] <= '0;
						fib_q[ix] <= '0; fil_q[ix] <= '0; fob_q[ix] <= '0;
						fol_q[ix] <= '0; from_q[ix] <= '0;
						idx_q <= idx_q + 1'b1;
					end else if (fol_q[ix] != 0 && out_over) begin
						// swap in the queued source; its fade-in, if any, starts now with delta zero
						pend_q[ix] <= 1'b0;
						cur_q[ix]  <= (qfin_q[ix] != 0) ? 8'd0 : tgt_q[ix];
						fib_q[ix]  <= (qfin_q[ix] != 0) ? now_in_q : 32'd0;
						fil_q[ix]  <= qfin_q[ix];
						qfin_q[ix] <= '0;
						fob_q[ix]  <= '0;
						fol_q[ix]  <= '0;
						idx_q      <= idx_q + 1'b1;
					end else if (fol_q[ix] != 0) begin
						prod_s1   <= 24'(from_q[ix]) * 24'(fol_q[ix] - dout[15:0]);
						len_s1    <= fol_q[ix];
						div_start <= 1'b1;
						state_q   <= S_DIV;
					end else if (fil_q[ix] != 0 && in_over) begin
						fib_q[ix] <= '0;
						fil_q[ix] <= '0;
						idx_q     <= idx_q + 1'b1;
					end else if (fil_q[ix] != 0) begin
						prod_s1   <= 24'(tgt_q[ix]) * 24'(din[15:0]);
						len_s1    <= fil_q[ix];
						div_start <= 1'b1;
						state_q   <= S_DIV;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cur_q[ix] <= div_quo;
						idx_q     <= idx_q + 1'b1;
						state_q   <= S_TCH;
					end
				end
				S_REP: begin
					out_channel <= 3'(idx_q);
					out_level   <= cur_q[ix];
					is_active   <= act_q[ix];
					fade_phase  <= (fol_q[ix] != 0) ? PHASE_OUT :
					               ((fil_q[ix] != 0) ? PHASE_IN : PHASE_STEADY);
					last        <= (idx_q == (CW+1)'(REP - 1));
					out_valid   <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					// hold the result until it is transferred
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last) state_q <= S_IDLE;
						else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_REP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign div_num = prod_s1;
	assign div_den = len_s1;
endmodule

// ===== hdl/ccvc_checker.sv =====
// Port-level checker for the channel crossfade volume controller.
// Depends on ccvc_pkg; bound to the top level at the end of this file.
module ccvc_checker
	import ccvc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_level,
	input logic [1:0] fade_phase,
	input logic [2:0] out_channel
);
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_level <= MAX_LEVEL) else $error("level above limit");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fade_phase <= PHASE_OUT) else $error("bad phase");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_channel))
		else $error("stalled result changed");
endmodule

bind channel_crossfade_volume_controller_top ccvc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_level(out_level),
	.fade_phase(fade_phase), .out_channel(out_channel)
);
